### src/fpas_pkg.sv
package fpas_pkg;

  localparam int unsigned InAddrW  = 40;
  localparam int unsigned RadixW   = 17;
  localparam int unsigned RemW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 17;

  localparam logic [CfgIdxW-1:0] RegChannel = 3'd0;
  localparam logic [CfgIdxW-1:0] RegWay     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDie     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPlane   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegBlock   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegPage    = 3'd5;
  localparam logic [CfgIdxW-1:0] RegOrder   = 3'd6;

  localparam logic [1:0] LvlChannel = 2'd0;
  localparam logic [1:0] LvlWay     = 2'd1;
  localparam logic [1:0] LvlDie     = 2'd2;
  localparam logic [1:0] LvlPlane   = 2'd3;

  typedef struct packed {
    logic [7:0]  channel;
    logic [7:0]  way;
    logic [3:0]  die;
    logic [2:0]  plane;
    logic [15:0] blk;
  } coord_t;

  // Zero acts as one, anything above the maximum acts as the maximum.
  function automatic logic [RadixW-1:0] eff_radix(input logic [RadixW-1:0] cnt,
                                                  input logic [RadixW-1:0] max);
    logic [RadixW-1:0] r;
    if (cnt == '0) begin
      r = RadixW'(1);
    end else if (cnt > max) begin
      r = max;
    end else begin
      r = cnt;
    end
    return r;
  endfunction

endpackage

### src/fpas_if.sv
interface fpas_in_if;
  logic                          valid;
  logic                          ready;
  logic [fpas_pkg::InAddrW-1:0]  linear_address;
  modport source (output valid, output linear_address, input ready);
  modport sink   (input valid, input linear_address, output ready);
endinterface

interface fpas_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  channel_index;
  logic [7:0]  way_index;
  logic [3:0]  die_index;
  logic [2:0]  plane_index;
  logic [15:0] block_index;
  logic [11:0] page_index;
  modport source (output valid, output channel_index, output way_index, output die_index,
                  output plane_index, output block_index, output page_index, input ready);
  modport sink   (input valid, input channel_index, input way_index, input die_index,
                  input plane_index, input block_index, input page_index, output ready);
endinterface

interface fpas_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fpas_pkg::CfgIdxW-1:0]   index;
  logic [fpas_pkg::CfgDataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### src/fpas_div.sv
module fpas_div #(
  parameter int unsigned AW  = 40,
  parameter int unsigned SW  = 39,
  parameter int unsigned BPS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [AW-1:0]                 num_i,
  input  logic [fpas_pkg::RadixW-1:0]   den_i,
  input  logic [SW-1:0]                 side_i,
  output logic                          valid_o,
  output logic [AW-1:0]                 quo_o,
  output logic [fpas_pkg::RadixW-1:0]   rem_o,
  output logic [SW-1:0]                 side_o
);
  import fpas_pkg::*;

  localparam int unsigned NST = (AW + BPS - 1) / BPS;

  logic [AW-1:0]     num_q  [NST];
  logic [RadixW-1:0] rem_q  [NST];
  logic [SW-1:0]     side_q [NST];
  logic [NST-1:0]    vld_q;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    localparam int unsigned NB = ((AW - s * BPS) < BPS) ? (AW - s * BPS) : BPS;
    logic [AW-1:0]     num_in, num_d;
    logic [RadixW-1:0] rem_in, rem_d;
    logic [SW-1:0]     side_in;
    logic              vld_in;

    if (s == 0) begin : g_first
      assign num_in  = num_i;
      assign rem_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign num_in  = num_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign side_in = side_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    // Restoring division: shift the top numerator bit into the remainder,
    // subtract when it fits and shift the quotient bit in at the bottom.
    always_comb begin
      logic [RadixW:0] t;
      logic [AW-1:0]   n;
      logic [RadixW-1:0] r;
      n = num_in;
      r = rem_in;
      for (int j = 0; j < NB; j++) begin
        t = {r, n[AW-1]};
        n = {n[AW-2:0], 1'b0};
        if (t >= {1'b0, den_i}) begin
          t    = t - {1'b0, den_i};
          n[0] = 1'b1;
        end
        r = t[RadixW-1:0];
      end
      num_d = n;
      rem_d = r;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else if (en_i) begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s]  <= num_d;
        rem_q[s]  <= rem_d;
        side_q[s] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[NST-1];
  assign quo_o   = num_q[NST-1];
  assign rem_o   = rem_q[NST-1];
  assign side_o  = side_q[NST-1];

endmodule

### src/flash_page_address_splitter.sv
// Six chained radix dividers, each retiring 8 quotient bits per register stage.
// Throughput: one word per cycle; a stall at the output holds the whole pipeline.
// Reset clears all valid bits and loads the count and order registers with their
// default values; no clearing pass.
module flash_page_address_splitter #(
  parameter int unsigned ADDR_BITS = 40
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  fpas_in_if.sink       in_i,
  fpas_out_if.source    out_o,
  fpas_cfg_if.sink      cfg_i
);
  import fpas_pkg::*;

  localparam int unsigned AW = ADDR_BITS;
  localparam int unsigned SW = $bits(coord_t);

  logic [8:0]  chan_cnt_q, way_cnt_q;
  logic [4:0]  die_cnt_q;
  logic [3:0]  plane_cnt_q;
  logic [16:0] blk_cnt_q;
  logic [12:0] page_cnt_q;
  logic [7:0]  order_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_cnt_q  <= 9'd8;
      way_cnt_q   <= 9'd4;
      die_cnt_q   <= 5'd1;
      plane_cnt_q <= 4'd2;
      blk_cnt_q   <= 17'd1024;
      page_cnt_q  <= 13'd256;
      order_q     <= 8'd228;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        RegChannel: chan_cnt_q  <= cfg_i.data[8:0];
        RegWay:     way_cnt_q   <= cfg_i.data[8:0];
        RegDie:     die_cnt_q   <= cfg_i.data[4:0];
        RegPlane:   plane_cnt_q <= cfg_i.data[3:0];
        RegBlock:   blk_cnt_q   <= cfg_i.data;
        RegPage:    page_cnt_q  <= cfg_i.data[12:0];
        RegOrder:   order_q     <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  logic [RadixW-1:0] lvl_radix [4];
  assign lvl_radix[0] = eff_radix(RadixW'(chan_cnt_q), RadixW'(256));
  assign lvl_radix[1] = eff_radix(RadixW'(way_cnt_q), RadixW'(256));
  assign lvl_radix[2] = eff_radix(RadixW'(die_cnt_q), RadixW'(16));
  assign lvl_radix[3] = eff_radix(RadixW'(plane_cnt_q), RadixW'(8));

  logic [RadixW-1:0] den [6];
  for (genvar k = 0; k < 4; k++) begin : g_den
    assign den[k] = lvl_radix[order_q[2*k +: 2]];
  end
  assign den[4] = eff_radix(blk_cnt_q, RadixW'(65536));
  assign den[5] = eff_radix(RadixW'(page_cnt_q), RadixW'(4096));

  logic en;
  logic out_vld_q;
  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  logic [AW-1:0] addr;
  if (AW <= InAddrW) begin : g_trunc
    assign addr = in_i.linear_address[AW-1:0];
  end else begin : g_ext
    assign addr = AW'(in_i.linear_address);
  end

  logic              d_vld  [6];
  logic [AW-1:0]     d_quo  [6];
  logic [RadixW-1:0] d_rem  [6];
  logic [SW-1:0]     d_side [6];
  coord_t            upd    [5];

  for (genvar k = 0; k < 6; k++) begin : g_digit
    logic          v_in;
    logic [AW-1:0] n_in;
    logic [SW-1:0] s_in;
    if (k == 0) begin : g_head
      assign v_in = in_i.valid;
      assign n_in = addr;
      assign s_in = '0;
    end else begin : g_chain
      assign v_in = d_vld[k-1];
      assign n_in = d_quo[k-1];
      assign s_in = upd[k-1];
    end

    fpas_div #(.AW(AW), .SW(SW), .BPS(8)) u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (v_in),
      .num_i   (n_in),
      .den_i   (den[k]),
      .side_i  (s_in),
      .valid_o (d_vld[k]),
      .quo_o   (d_quo[k]),
      .rem_o   (d_rem[k]),
      .side_o  (d_side[k])
    );
  end

  // Drop each remainder into the coordinate its digit names.
  for (genvar k = 0; k < 4; k++) begin : g_upd
    always_comb begin
      upd[k] = coord_t'(d_side[k]);
      case (order_q[2*k +: 2])
        LvlChannel: upd[k].channel = d_rem[k][7:0];
        LvlWay:     upd[k].way     = d_rem[k][7:0];
        LvlDie:     upd[k].die     = d_rem[k][3:0];
        LvlPlane:   upd[k].plane   = d_rem[k][2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    upd[4]     = coord_t'(d_side[4]);
    upd[4].blk = d_rem[4][15:0];
  end

  coord_t      out_crd_q;
  logic [11:0] out_page_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_vld[5];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_crd_q  <= coord_t'(d_side[5]);
      out_page_q <= d_rem[5][11:0];
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.channel_index = out_crd_q.channel;
  assign out_o.way_index     = out_crd_q.way;
  assign out_o.die_index     = out_crd_q.die;
  assign out_o.plane_index   = out_crd_q.plane;
  assign out_o.block_index   = out_crd_q.blk;
  assign out_o.page_index    = out_page_q;

endmodule

### test/fpas_checker.sv
module fpas_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  fpas_in_if          in_i,
  fpas_out_if         out_o,
  fpas_cfg_if         cfg_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import fpas_pkg::*;

  typedef struct packed {
    logic [7:0]  channel;
    logic [7:0]  way;
    logic [3:0]  die;
    logic [2:0]  plane;
    logic [15:0] blk;
    logic [11:0] page;
  } page_coord_t;

  logic [16:0] radix_q [6];
  logic [7:0]  order_q;
  page_coord_t coord_queue [$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = coord_queue.size();

  function automatic logic [16:0] clamp_count(logic [16:0] cnt, logic [16:0] top);
    if (cnt == '0) return 17'd1;
    if (cnt > top) return top;
    return cnt;
  endfunction

  function automatic page_coord_t split_address(logic [InAddrW-1:0] addr_in);
    logic [63:0] addr;
    logic [63:0] digit [6];
    logic [63:0] r;
    logic [1:0]  lvl;
    logic [16:0] tops [6];
    page_coord_t c;
    tops = '{17'd256, 17'd256, 17'd16, 17'd8, 17'd65536, 17'd4096};
    addr = 64'(addr_in);
    for (int k = 0; k < 6; k++) digit[k] = '0;
    for (int i = 0; i < 4; i++) begin
      lvl = order_q[2*i +: 2];
      r = 64'(clamp_count(radix_q[lvl], tops[lvl]));
      digit[lvl] = addr % r;
      addr = addr / r;
    end
    r = 64'(clamp_count(radix_q[RegBlock], tops[4]));
    digit[4] = addr % r;
    addr = addr / r;
    digit[5] = addr % 64'(clamp_count(radix_q[RegPage], tops[5]));
    c.channel = digit[LvlChannel][7:0];
    c.way     = digit[LvlWay][7:0];
    c.die     = digit[LvlDie][3:0];
    c.plane   = digit[LvlPlane][2:0];
    c.blk     = digit[4][15:0];
    c.page    = digit[5][11:0];
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    page_coord_t want, got;
    if (!rst_ni) begin
      radix_q[0] <= 17'd8;
      radix_q[1] <= 17'd4;
      radix_q[2] <= 17'd1;
      radix_q[3] <= 17'd2;
      radix_q[4] <= 17'd1024;
      radix_q[5] <= 17'd256;
      order_q    <= 8'd228;
      coord_queue.delete();
      fails = 0;
    end else begin
      if (in_i.valid && in_i.ready) coord_queue.push_back(split_address(in_i.linear_address));
      if (out_o.valid && out_o.ready) begin
        got = {out_o.channel_index, out_o.way_index, out_o.die_index, out_o.plane_index,
               out_o.block_index, out_o.page_index};
        if (coord_queue.size() == 0) begin
          $display("%0t: unexpected word, actual %h", $time, got);
          fails++;
        end else begin
          want = coord_queue.pop_front();
          if (want !== got) begin
            $display("%0t: mismatch, expected ch %0d way %0d die %0d pl %0d blk %0d pg %0d",
                     $time, want.channel, want.way, want.die, want.plane, want.blk, want.page);
            $display("%0t:           actual ch %0d way %0d die %0d pl %0d blk %0d pg %0d",
                     $time, got.channel, got.way, got.die, got.plane, got.blk, got.page);
            fails++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          RegChannel: radix_q[0] <= {8'd0, cfg_i.data[8:0]};
          RegWay:     radix_q[1] <= {8'd0, cfg_i.data[8:0]};
          RegDie:     radix_q[2] <= {12'd0, cfg_i.data[4:0]};
          RegPlane:   radix_q[3] <= {13'd0, cfg_i.data[3:0]};
          RegBlock:   radix_q[4] <= cfg_i.data[16:0];
          RegPage:    radix_q[5] <= {4'd0, cfg_i.data[12:0]};
          RegOrder:   order_q    <= cfg_i.data[7:0];
          default: ;
        endcase
      end
    end
  end
endmodule

### test/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fpas_pkg::*;

  localparam int unsigned DrainCycles = 60;
  localparam longint unsigned CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned fail_count, pending;
  longint unsigned cycles = 0;
  int unsigned burst_left = 0, gap_left = 0, stall_phase = 0, stall_mode = 0;

  fpas_in_if  in_if ();
  fpas_out_if out_if ();
  fpas_cfg_if cfg_if ();

  flash_page_address_splitter u_top (
    .clk_i(clk), .rst_ni(rst_n), .in_i(in_if.sink), .out_o(out_if.source), .cfg_i(cfg_if.sink)
  );

  fpas_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n), .in_i(in_if), .out_o(out_if), .cfg_i(cfg_if),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.linear_address = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
  end

  // Receiver stall pattern: mode switches now and then between none, periodic and random.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    stall_phase <= stall_phase + 1;
    if (stall_phase % 500 == 499) stall_mode <= $urandom_range(0, 2);
    if (!rst_n) out_if.ready <= 1'b0;
    else case (stall_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= (stall_phase % 7) < 4;
      default: out_if.ready <= $urandom_range(0, 3) != 0;
    endcase
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_word(input logic [InAddrW-1:0] addr);
    while (gap_left > 0) begin
      @(posedge clk);
      gap_left--;
    end
    in_if.valid <= 1'b1;
    in_if.linear_address <= addr;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 20);
      gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    if (gap_left > 0) in_if.valid <= 1'b0;
  endtask

  // A pending gap has already dropped valid.
  task automatic drain;
    if (gap_left == 0) in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Leave valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
  endtask

  task automatic set_geometry(input logic [16:0] ch, way, die, pl, blk, pg, input logic [7:0] ord);
    write_reg(RegChannel, ch);
    write_reg(RegWay, way);
    write_reg(RegDie, die);
    write_reg(RegPlane, pl);
    write_reg(RegBlock, blk);
    write_reg(RegPage, pg);
    write_reg(RegOrder, {9'd0, ord});
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [InAddrW-1:0] rand_address();
    logic [InAddrW-1:0] a;
    a = InAddrW'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: a = a >> $urandom_range(0, 39);
      1: a = ~(a >> $urandom_range(0, 39));
      default: ;
    endcase
    return a;
  endfunction

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) send_word(rand_address());
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: reset geometry, address extremes
    send_word('0);
    send_word('1);
    send_word(40'd1);
    send_word(40'h80_0000_0000);
    send_word(40'd63);
    send_word(40'd65535);
    drain();
    // all counts at max, zero counts, oversized counts, repeated and unnamed levels
    set_geometry(17'd256, 17'd256, 17'd16, 17'd8, 17'd65536, 17'd4096, 8'b00_01_10_11);
    send_word('1); send_word('0); send_word(40'h55_5555_5555); send_word(40'hAA_AAAA_AAAA);
    drain();
    set_geometry(17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 8'd0);
    send_word('1); send_word(40'd12345);
    drain();
    set_geometry(17'h1FF, 17'h1FF, 17'h1F, 17'hF, 17'h1FFFF, 17'h1FFF, 8'hFF);
    send_word('1); send_word(40'h12_3456_789A); send_word(40'd999);
    drain();
    set_geometry(17'd3, 17'd5, 17'd7, 17'd3, 17'd1000, 17'd1, 8'b01_01_00_10);
    send_word('1); send_word(40'd104); send_word(40'h0F_0F0F_0F0F);
    drain();
    // unknown register index is ignored
    write_reg(3'd7, 17'h1FFFF);
    cfg_if.valid <= 1'b0;
    send_word(40'd777);
    drain();
    // random phases under random geometry
    for (int p = 0; p < 14; p++) begin
      set_geometry(17'($urandom_range(0, 511)), 17'($urandom_range(0, 511)),
                   17'($urandom_range(0, 31)), 17'($urandom_range(0, 15)),
                   ($urandom_range(0, 3) == 0) ? 17'($urandom_range(0, 17'h1FFFF))
                                               : 17'($urandom_range(1, 2048)),
                   17'($urandom_range(0, 17'h1FFF)), 8'($urandom_range(0, 255)));
      random_phase(50);
    end
    drain();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
